>>> rtl/core/rpn_pkg.sv
package rpn_pkg;

  localparam int Depth = 16;
  localparam int FracBits = 32;
  localparam int CntW = 5;
  localparam logic [63:0] SignBit = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MaxPos = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [3:0] {
    OP_PUSH = 4'd0, OP_ADD = 4'd1, OP_SUB = 4'd2, OP_MUL = 4'd3,
    OP_DIV = 4'd4, OP_SQR = 4'd5, OP_SQRT = 4'd6, OP_RECIP = 4'd7,
    OP_DROP = 4'd8, OP_SWAP = 4'd9, OP_ROT = 4'd10
  } op_t;

  typedef enum logic [1:0] {
    ERR_OK = 2'd0, ERR_UNDER = 2'd1, ERR_OVER = 2'd2, ERR_MATH = 2'd3
  } err_t;

  // Per-cell command issued to every cell of the stack chain.
  typedef enum logic [2:0] {
    CC_HOLD = 3'd0, CC_LOAD = 3'd1, CC_DOWN = 3'd2, CC_UP = 3'd3
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    logic [63:0] data;
  } cell_ctl_t;

  function automatic logic [63:0] magnitude(input logic [63:0] v);
    magnitude = v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic [63:0] apply_sign(input logic neg, input logic [63:0] m,
                                             input logic ovf);
    if (neg) begin
      apply_sign = (ovf || m > SignBit) ? SignBit : (64'd0 - m);
    end else begin
      apply_sign = (ovf || m > MaxPos) ? MaxPos : m;
    end
  endfunction

endpackage

>>> rtl/core/rpn_cell.sv
module rpn_cell (
  input  logic                  clk,
  input  rpn_pkg::cell_ctl_t    ctl,
  input  logic                  sel,
  input  logic                  sel_load,
  input  logic [63:0]           from_above,
  input  logic [63:0]           from_below,
  output logic [63:0]           value
);

  // One stack slot: load, take the neighbor's value, or hold.
  always_ff @(posedge clk) begin
    if (sel_load) begin
      value <= ctl.data;
    end else if (sel) begin
      unique case (ctl.cmd)
        rpn_pkg::CC_DOWN: value <= from_above;
        rpn_pkg::CC_UP:   value <= from_below;
        default:          value <= value;
      endcase
    end
  end

endmodule

>>> rtl/core/rpn_alu.sv
module rpn_alu (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        is_sqrt,
  input  logic        is_mul,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] result
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_MUL = 4'b0010, S_DIV = 4'b0100, S_SQRT = 4'b1000
  } alu_state_t;

  alu_state_t state;
  logic [6:0] step;
  logic [127:0] num;
  logic [64:0] rem;
  logic [63:0] q, d, root;
  logic neg, ovf;
  logic [127:0] prod;
  logic [1:0] part;
  logic [64:0] trial;
  logic [63:0] am, bm;
  logic [31:0] mpa, mpb;
  logic [63:0] pp;
  logic [66:0] sq_acc;
  logic [67:0] sq_trial;

  assign am = rpn_pkg::magnitude(a);
  assign bm = rpn_pkg::magnitude(b);
  assign trial = {rem[63:0], num[127]} - {1'b0, d};
  assign mpa = part[0] ? num[63:32] : num[31:0];
  assign mpb = part[1] ? d[63:32] : d[31:0];
  assign pp = mpa * mpb;
  // Square root: bring down two radicand bits, try (root << 2) | 1.
  assign sq_acc = {rem, num[127:126]};
  assign sq_trial = {1'b0, sq_acc} - {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: if (start) begin
          neg <= (a[63] ^ b[63]);
          d <= bm;
          rem <= '0;
          q <= '0;
          ovf <= 1'b0;
          root <= '0;
          prod <= '0;
          part <= 2'd0;
          if (is_mul) begin
            num <= {64'd0, am};
            state <= S_MUL;
          end else if (is_sqrt) begin
            num <= {b, 64'd0} >> (64 - rpn_pkg::FracBits);
            step <= 7'd63;
            state <= S_SQRT;
          end else begin
            num <= {am, 64'd0} >> (64 - rpn_pkg::FracBits);
            step <= 7'd127;
            state <= S_DIV;
          end
        end
        S_MUL: begin
          prod <= prod + ({64'd0, pp} << ({5'd0, part[0] + part[1]} * 7'd32));
          part <= part + 2'd1;
          if (part == 2'd3) begin
            state <= S_IDLE;
            done <= 1'b1;
            result <= rpn_pkg::apply_sign(neg,
                        prod[rpn_pkg::FracBits +: 64] + (pp << (64 - rpn_pkg::FracBits)),
                        ((prod + ({64'd0, pp} << 64)) >> (64 + rpn_pkg::FracBits)) != 0);
          end
        end
        S_DIV: begin
          if (!trial[64]) rem <= trial;
          else rem <= {rem[63:0], num[127]};
          num <= num << 1;
          if (q[63]) ovf <= 1'b1;
          q <= {q[62:0], ~trial[64]};
          step <= step - 7'd1;
          if (step == 7'd0) begin
            state <= S_IDLE;
            done <= 1'b1;
            result <= rpn_pkg::apply_sign(neg, {q[62:0], ~trial[64]}, ovf | q[63]);
          end
        end
        S_SQRT: begin
          // One root bit per cycle.
          if (!sq_trial[67]) begin
            rem <= sq_trial[64:0];
            root <= {root[62:0], 1'b1};
          end else begin
            rem <= sq_acc[64:0];
            root <= {root[62:0], 1'b0};
          end
          num <= num << 2;
          step <= step - 7'd1;
          if (step == 7'd0) begin
            state <= S_IDLE;
            done <= 1'b1;
            result <= {root[62:0], ~sq_trial[67]};
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/rpn_stack_calculator.sv
// RPN calculator on a 16-entry stack of signed Q32.32 values.
// Input channel s_axis: one beat per operation (mode, operand, rotate count).
// Output channel m_axis: one beat per operation with the new top value,
// depth, whole-number flag and error code.
// The stack is a row of cells; slot 0 is the bottom. Rotates and swaps
// shift the selected cells one position at once, in the ROT state.
// Path from accept to result beat: push/add/sub/drop and any error
// go from EXEC to OUT; swap/rotate pass through ROT; multiply and square
// wait on the ALU for four 32x32 partial products; divide and reciprocal
// take one quotient bit per cycle over 128 bits; square root one root bit
// per cycle. One operation is in flight at a time: s_axis_tready is low
// from accept until its result beat has been taken, then high again the
// next cycle.
// A stalled m_axis holds its beat until m_axis_tready.
// Reset empties the stack and drops any beat in flight.
module rpn_stack_calculator (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [79:0]  s_axis_tdata,  // mode[3:0], operand[67:4], rotate_count[73:68]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [71:0]  m_axis_tdata   // top_value[63:0], stack_depth[68:64],
                                      // top_is_whole[69], error_code[71:70]
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001, ST_EXEC = 5'b00010, ST_WAIT = 5'b00100,
    ST_ROT = 5'b01000, ST_OUT = 5'b10000
  } st_t;

  st_t state;
  logic [3:0] mode;
  logic [63:0] operand;
  logic signed [5:0] rcnt;
  logic [4:0] n;
  logic [1:0] err;
  logic [63:0] cells [rpn_pkg::Depth];
  logic [rpn_pkg::Depth-1:0] sel, sel_load;
  rpn_pkg::cell_ctl_t ctl;
  logic [63:0] a, b, sum, dif, top;
  logic alu_start, alu_done;
  logic [63:0] alu_res;
  logic [4:0] lo_idx;
  logic [1:0] chk_err;
  logic [4:0] need;

  assign b = (n != 5'd0) ? cells[n[3:0] - 4'd1] : 64'd0;
  assign a = (n >= 5'd2) ? cells[n[3:0] - 4'd2] : 64'd0;
  assign sum = a + b;
  assign dif = a - b;
  assign top = (n != 5'd0) ? cells[n[3:0] - 4'd1] : 64'd0;

  genvar g;
  generate
    for (g = 0; g < rpn_pkg::Depth; g++) begin : g_cell
      logic [63:0] above, below;
      if (g == rpn_pkg::Depth - 1) begin : g_t
        assign above = cells[g];
      end else begin : g_a
        assign above = cells[g+1];
      end
      if (g == 0) begin : g_b
        assign below = cells[g];
      end else begin : g_bl
        assign below = cells[g-1];
      end
      rpn_cell u_cell (
        .clk(clk), .ctl(ctl), .sel(sel[g]), .sel_load(sel_load[g]),
        .from_above(below), .from_below(above), .value(cells[g])
      );
    end
  endgenerate

  rpn_alu u_alu (
    .clk(clk), .rst(rst), .start(alu_start),
    .is_sqrt(mode == rpn_pkg::OP_SQRT), .is_mul(mode == rpn_pkg::OP_MUL ||
             mode == rpn_pkg::OP_SQR),
    .a((mode == rpn_pkg::OP_SQR) ? b : (mode == rpn_pkg::OP_RECIP) ?
       (64'd1 << rpn_pkg::FracBits) : a),
    .b(b), .done(alu_done), .result(alu_res)
  );

  logic [5:0] k;
  assign k = rcnt[5] ? -rcnt : rcnt;
  assign lo_idx = n - k[4:0];

  logic is_math;
  assign is_math = (mode == rpn_pkg::OP_MUL) || (mode == rpn_pkg::OP_DIV) ||
                   (mode == rpn_pkg::OP_SQR) || (mode == rpn_pkg::OP_SQRT) ||
                   (mode == rpn_pkg::OP_RECIP);

  // Rotate: CC_DOWN moves each cell from the one below (toward the top),
  // then reload the lowest slot; CC_UP the reverse.
  logic [63:0] rot_tmp;

  always_comb begin
    sel = '0;
    sel_load = '0;
    ctl.cmd = rpn_pkg::CC_HOLD;
    ctl.data = '0;
    alu_start = 1'b0;
    if (state == ST_EXEC) begin
      priority if (mode == rpn_pkg::OP_PUSH) begin
        if (n < 5'(rpn_pkg::Depth)) begin
          sel_load[n[3:0]] = 1'b1;
          ctl.data = operand;
        end
      end else if (mode == rpn_pkg::OP_ADD && n >= 5'd2) begin
        sel_load[n[3:0] - 4'd2] = 1'b1;
        ctl.data = (!(a[63] ^ b[63]) && (sum[63] ^ a[63])) ?
                   (a[63] ? rpn_pkg::SignBit : rpn_pkg::MaxPos) : sum;
      end else if (mode == rpn_pkg::OP_SUB && n >= 5'd2) begin
        sel_load[n[3:0] - 4'd2] = 1'b1;
        ctl.data = ((a[63] ^ b[63]) && (dif[63] ^ a[63])) ?
                   (a[63] ? rpn_pkg::SignBit : rpn_pkg::MaxPos) : dif;
      end else if (is_math) begin
        alu_start = (chk_err == rpn_pkg::ERR_OK);
      end else begin
      end
    end else if (state == ST_WAIT && alu_done) begin
      sel_load[n[3:0] - ((mode == rpn_pkg::OP_MUL || mode == rpn_pkg::OP_DIV) ?
                         4'd2 : 4'd1)] = 1'b1;
      ctl.data = alu_res;
    end else if (state == ST_ROT) begin
      for (int i = 0; i < rpn_pkg::Depth; i++) begin
        if (5'(i) >= lo_idx && 5'(i) < n) sel[i] = 1'b1;
      end
      if (!rcnt[5]) begin
        ctl.cmd = rpn_pkg::CC_DOWN;
        sel[lo_idx[3:0]] = 1'b0;
        sel_load[lo_idx[3:0]] = 1'b1;
        ctl.data = rot_tmp;
      end else begin
        ctl.cmd = rpn_pkg::CC_UP;
        sel[n[3:0] - 4'd1] = 1'b0;
        sel_load[n[3:0] - 4'd1] = 1'b1;
        ctl.data = rot_tmp;
      end
    end
  end

  always_comb begin
    unique case (mode)
      rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL, rpn_pkg::OP_DIV,
      rpn_pkg::OP_SWAP: need = 5'd2;
      rpn_pkg::OP_SQR, rpn_pkg::OP_SQRT, rpn_pkg::OP_RECIP,
      rpn_pkg::OP_DROP: need = 5'd1;
      default: need = 5'd0;
    endcase
    chk_err = rpn_pkg::ERR_OK;
    if (n < need) chk_err = rpn_pkg::ERR_UNDER;
    else if (mode == rpn_pkg::OP_PUSH && n >= 5'(rpn_pkg::Depth))
      chk_err = rpn_pkg::ERR_OVER;
    else if ((mode == rpn_pkg::OP_DIV || mode == rpn_pkg::OP_RECIP) && b == 64'd0)
      chk_err = rpn_pkg::ERR_MATH;
    else if (mode == rpn_pkg::OP_SQRT && b[63])
      chk_err = rpn_pkg::ERR_MATH;
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata = {err, (top[rpn_pkg::FracBits-1:0] == '0), n, top};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      n <= '0;
      err <= rpn_pkg::ERR_OK;
    end else begin
      unique case (state)
        ST_IDLE: if (s_axis_tvalid) begin
          mode <= s_axis_tdata[3:0];
          operand <= s_axis_tdata[67:4];
          rcnt <= s_axis_tdata[73:68];
          err <= rpn_pkg::ERR_OK;
          state <= ST_EXEC;
        end
        ST_EXEC: begin
          err <= chk_err;
          if (chk_err != rpn_pkg::ERR_OK) begin
            state <= ST_OUT;
          end else if (is_math) begin
            state <= ST_WAIT;
          end else if (mode == rpn_pkg::OP_ROT && rcnt != 6'd0 && k <= {1'b0, n}) begin
            rot_tmp <= rcnt[5] ? cells[lo_idx[3:0]] : cells[n[3:0] - 4'd1];
            state <= ST_ROT;
          end else if (mode == rpn_pkg::OP_SWAP) begin
            // Swap is a rotate down of the top two entries.
            rcnt <= 6'sd2;
            rot_tmp <= b;
            state <= ST_ROT;
          end else begin
            if (mode == rpn_pkg::OP_PUSH) n <= n + 5'd1;
            if (mode == rpn_pkg::OP_ADD || mode == rpn_pkg::OP_SUB ||
                mode == rpn_pkg::OP_DROP) n <= n - 5'd1;
            state <= ST_OUT;
          end
        end
        ST_WAIT: if (alu_done) begin
          if (mode == rpn_pkg::OP_MUL || mode == rpn_pkg::OP_DIV) n <= n - 5'd1;
          state <= ST_OUT;
        end
        ST_ROT: state <= ST_OUT;
        ST_OUT: if (m_axis_tready) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_depth: assert property (@(posedge clk) disable iff (rst) n <= 5'(rpn_pkg::Depth))
    else $error("stack depth exceeds capacity");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && !m_axis_tready) |=> $stable(n))
    else $error("depth changed while result stalled");
  a_noacc: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_axis_tready)
    else $error("input accepted while busy");
`endif

endmodule
